/* rtl/tsfd_pkg.sv */
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
`default_nettype none

package tsfd_pkg;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  CRC_INIT     = 8'hFF;

    localparam int          PROD_W       = 31;
    localparam logic [16:0] WORD_SPAN    = 17'd65535;

    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [14:0] HUM_SCALE_A  = 15'd10000;
    localparam logic [14:0] HUM_SCALE_B  = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
    localparam logic [15:0] HUM_OFFSET_B = 16'd600;

    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic        temp_crc_ok;
        logic        hum_crc_ok;
        logic        sensor_kind;
    } t_frame;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/tsfd_if.sv */
// Channel interfaces: received frame bytes in, decoded samples out.
`default_nettype none

interface tsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tsfd_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        raw_temperature;
    logic [15:0]        raw_humidity;
    logic signed [14:0] temperature_centi;
    logic signed [14:0] humidity_centi;
    logic               temp_crc_ok;
    logic               hum_crc_ok;
    logic               sample_valid;

    modport source (output valid, output raw_temperature, output raw_humidity,
                    output temperature_centi, output humidity_centi,
                    output temp_crc_ok, output hum_crc_ok, output sample_valid,
                    input ready);
    modport sink   (input valid, input raw_temperature, input raw_humidity,
                    input temperature_centi, input humidity_centi,
                    input temp_crc_ok, input hum_crc_ok, input sample_valid,
                    output ready);
endinterface

`default_nettype wire

/* rtl/th_sensor_frame_decoder_unit.sv */
// Top level of the temperature/humidity sensor frame decoder.
// Accepts one frame byte per cycle while i_byte.ready is high: temperature MSB, LSB, CRC, then
// humidity MSB, LSB, CRC; frame_start forces byte 0. Each sixth byte yields one
// sample, registered in the frame assembler, then in the multiplier stage, then
// in the divide-by-65535 and offset stage. Bytes 0 to 4 yield nothing. CRC
// failures still yield a sample with the flags cleared. Write sensor_kind only
// while no sample is in flight.
`default_nettype none

module th_sensor_frame_decoder_unit import tsfd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tsfd_byte_if.sink     i_byte,
    tsfd_result_if.source o_result,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata
);

    logic   r_sensor_kind;
    t_frame w_frame;
    logic   w_frame_valid;
    logic   w_frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_kind <= 1'b0;
        end else if (i_cfg_we) begin
            r_sensor_kind <= i_cfg_wdata;
        end
    end

    tsfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_byte),
        .i_sensor_kind (r_sensor_kind),
        .o_frame       (w_frame),
        .o_frame_valid (w_frame_valid),
        .i_frame_ready (w_frame_ready)
    );

    tsfd_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_frame),
        .i_frame_valid (w_frame_valid),
        .o_frame_ready (w_frame_ready),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire

/* rtl/tsfd_frame.sv */
// Frame assembler: byte position tracking, word capture and CRC-8 checks.
`default_nettype none

module tsfd_frame import tsfd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tsfd_byte_if.sink     i_byte,
    input  wire logic     i_sensor_kind,
    output t_frame        o_frame,
    output logic          o_frame_valid,
    input  wire logic     i_frame_ready
);

    typedef enum logic [2:0] {
        POS_T_MSB,
        POS_T_LSB,
        POS_T_CRC,
        POS_H_MSB,
        POS_H_LSB,
        POS_H_CRC
    } t_pos;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_first_ok, n_first_ok;
    logic        r_valid;
    t_frame      r_frame;

    t_pos        pos_eff;
    logic        accept;
    logic        last_byte;

    assign i_byte.ready = !r_valid || i_frame_ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign pos_eff      = (i_byte.frame_start || r_pos > POS_H_CRC) ? POS_T_MSB : r_pos;
    assign last_byte    = pos_eff == POS_H_CRC;

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_temp     = r_temp;
        n_hum      = r_hum;
        n_first_ok = r_first_ok;
        unique case (pos_eff)
            POS_T_MSB: begin
                n_crc       = crc8_byte(CRC_INIT, i_byte.data_byte);
                n_temp[15:8] = i_byte.data_byte;
                n_pos       = POS_T_LSB;
            end
            POS_T_LSB: begin
                n_crc       = crc8_byte(r_crc, i_byte.data_byte);
                n_temp[7:0] = i_byte.data_byte;
                n_pos       = POS_T_CRC;
            end
            POS_T_CRC: begin
                n_first_ok = r_crc == i_byte.data_byte;
                n_crc      = CRC_INIT;
                n_pos      = POS_H_MSB;
            end
            POS_H_MSB: begin
                n_crc       = crc8_byte(CRC_INIT, i_byte.data_byte);
                n_hum[15:8] = i_byte.data_byte;
                n_pos       = POS_H_LSB;
            end
            POS_H_LSB: begin
                n_crc      = crc8_byte(r_crc, i_byte.data_byte);
                n_hum[7:0] = i_byte.data_byte;
                n_pos      = POS_H_CRC;
            end
            default: begin
                n_crc = CRC_INIT;
                n_pos = POS_T_MSB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_T_MSB;
            r_crc      <= CRC_INIT;
            r_temp     <= '0;
            r_hum      <= '0;
            r_first_ok <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_temp     <= n_temp;
                r_hum      <= n_hum;
                r_first_ok <= n_first_ok;
            end
            if (accept && last_byte) begin
                r_valid                 <= 1'b1;
                r_frame.raw_temperature <= r_temp;
                r_frame.raw_humidity    <= r_hum;
                r_frame.temp_crc_ok     <= r_first_ok;
                r_frame.hum_crc_ok      <= r_crc == i_byte.data_byte;
                r_frame.sensor_kind     <= i_sensor_kind;
            end else if (i_frame_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_frame       = r_frame;
    assign o_frame_valid = r_valid;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_H_CRC)
        else $error("frame position out of range");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_byte) |=> (r_valid && r_pos == POS_T_MSB))
        else $error("sixth byte did not produce a frame");

    a_temp_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && pos_eff == POS_T_CRC) |=> (r_first_ok == $past(r_crc == i_byte.data_byte)))
        else $error("temperature CRC flag not captured");

    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_frame_ready) |=> (r_valid && $stable(r_frame)))
        else $error("pending frame lost under stall");

endmodule

`default_nettype wire

/* rtl/tsfd_scale.sv */
// Scaling pipeline: multiply by span, divide by 65535, apply offsets.
`default_nettype none

module tsfd_scale import tsfd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_frame   i_frame,
    input  wire logic     i_frame_valid,
    output logic          o_frame_ready,
    tsfd_result_if.source o_result
);

    function automatic logic [14:0] div_span(input t_prod p);
        logic [16:0] s;
        s = {2'b00, p[30:16]} + {1'b0, p[15:0]};
        return p[30:16] + {14'd0, s >= WORD_SPAN};
    endfunction

    logic        r_p_valid;
    t_prod       r_prod_t, r_prod_h;
    logic [15:0] r_p_raw_t, r_p_raw_h;
    logic        r_p_tok, r_p_hok, r_p_kind;

    logic               r_o_valid;
    logic [15:0]        r_o_raw_t, r_o_raw_h;
    logic signed [14:0] r_o_tc, r_o_hc;
    logic               r_o_tok, r_o_hok;

    t_prod       n_prod_t, n_prod_h;
    logic [14:0] hum_scale;
    logic [14:0] quo_t, quo_h;
    logic [15:0] hum_offset;
    logic [15:0] n_tc, n_hc;
    logic        out_ready, p_ready;

    assign out_ready     = !r_o_valid || o_result.ready;
    assign p_ready       = !r_p_valid || out_ready;
    assign o_frame_ready = p_ready;

    assign hum_scale = i_frame.sensor_kind ? HUM_SCALE_B : HUM_SCALE_A;
    assign n_prod_t  = TEMP_SCALE * i_frame.raw_temperature;
    assign n_prod_h  = hum_scale * i_frame.raw_humidity;

    assign quo_t      = div_span(r_prod_t);
    assign quo_h      = div_span(r_prod_h);
    assign hum_offset = r_p_kind ? HUM_OFFSET_B : 16'd0;
    assign n_tc       = {1'b0, quo_t} - TEMP_OFFSET;
    assign n_hc       = {1'b0, quo_h} - hum_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_frame_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_frame_valid) begin
            r_prod_t  <= n_prod_t;
            r_prod_h  <= n_prod_h;
            r_p_raw_t <= i_frame.raw_temperature;
            r_p_raw_h <= i_frame.raw_humidity;
            r_p_tok   <= i_frame.temp_crc_ok;
            r_p_hok   <= i_frame.hum_crc_ok;
            r_p_kind  <= i_frame.sensor_kind;
        end
        if (out_ready && r_p_valid) begin
            r_o_raw_t <= r_p_raw_t;
            r_o_raw_h <= r_p_raw_h;
            r_o_tc    <= $signed(n_tc[14:0]);
            r_o_hc    <= $signed(n_hc[14:0]);
            r_o_tok   <= r_p_tok;
            r_o_hok   <= r_p_hok;
        end
    end

    assign o_result.valid             = r_o_valid;
    assign o_result.raw_temperature   = r_o_raw_t;
    assign o_result.raw_humidity      = r_o_raw_h;
    assign o_result.temperature_centi = r_o_tc;
    assign o_result.humidity_centi    = r_o_hc;
    assign o_result.temp_crc_ok       = r_o_tok;
    assign o_result.hum_crc_ok        = r_o_hok;
    assign o_result.sample_valid      = r_o_tok && r_o_hok;

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && out_ready) |=> r_o_valid)
        else $error("product stage dropped a sample");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (quo_t <= TEMP_SCALE))
        else $error("temperature quotient out of range");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (quo_h <= HUM_SCALE_B))
        else $error("humidity quotient out of range");

endmodule

`default_nettype wire
